FILE: rtl/core/sbo_pkg.sv
// ----------------------------------------------------------------------------
// sbo_pkg: shared types for the segment/box overlap test
// Coordinate width and the widths of the doubled-value datapath.
// ----------------------------------------------------------------------------
package sbo_pkg;

  localparam int COORD_BITS = 24;
  // (start + end) - (min + max)
  localparam int CTR_W      = COORD_BITS + 2;
  // start - end, max - min
  localparam int DIF_W      = COORD_BITS + 1;
  // any of the cross-axis products
  localparam int PROD_W     = CTR_W + DIF_W;
  // sum or difference of two products
  localparam int ACC_W      = PROD_W + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [CTR_W-1:0]      ctr_t;
  typedef logic        [CTR_W-1:0]      ctr_mag_t;
  typedef logic signed [DIF_W-1:0]      dif_t;
  typedef logic        [DIF_W-1:0]      dif_mag_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [ACC_W-1:0]      acc_t;

endpackage

FILE: rtl/core/sbo_if.sv
// ----------------------------------------------------------------------------
// sbo_if: query and result channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sbo_req_if;
  import sbo_pkg::*;

  logic   valid;
  logic   ready;
  coord_t box_min_x;
  coord_t box_min_y;
  coord_t box_min_z;
  coord_t box_max_x;
  coord_t box_max_y;
  coord_t box_max_z;
  coord_t seg_start_x;
  coord_t seg_start_y;
  coord_t seg_start_z;
  coord_t seg_end_x;
  coord_t seg_end_y;
  coord_t seg_end_z;

  modport source (
    output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
           seg_start_x, seg_start_y, seg_start_z, seg_end_x, seg_end_y, seg_end_z,
    input  ready
  );
  modport sink (
    input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
           seg_start_x, seg_start_y, seg_start_z, seg_end_x, seg_end_y, seg_end_z,
    output ready
  );
endinterface

interface sbo_rsp_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

FILE: rtl/core/segment_box_overlap_test_core.sv
// ----------------------------------------------------------------------------
// segment_box_overlap_test_core: segment versus axis-aligned box overlap
// Separating-axis test over three face axes and three cross axes, on doubled
// values so that all arithmetic is exact.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one query word: box min/max corners and segment start/end,
//   signed Q16.8. rsp_o returns one word per query: hit = 1 when the segment
//   touches or crosses the box, 0 when some axis separates them.
// Pipeline: five register stages, the first loaded at the accepting edge
//   (doubled center/half-vector/extent, magnitudes, multipliers plus face
//   tests, product sums, final compare into the output register); the last
//   stage's valid bit drives rsp_o.valid.
// Throughput: one query per cycle, limited by nothing but the handshake; the
//   twelve 26x25 multipliers all sit in stage 3 and are fully pipelined.
// Stall: each stage holds while the stage after it is full and held, so
//   bubbles are squeezed out and req_i.ready stays high until every stage is
//   occupied behind a stalled rsp_o.
// Reset: all stage valid bits clear; the pipe is empty and req_i.ready is high.
// ----------------------------------------------------------------------------
module segment_box_overlap_test_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbo_req_if.sink    req_i,
  sbo_rsp_if.source  rsp_o
);
  import sbo_pkg::*;

  localparam int NSTG = 5;
  // cross axis k uses the pair (AX_A[k], AX_B[k])
  localparam int AX_A [3] = '{1, 0, 0};
  localparam int AX_B [3] = '{2, 2, 1};

  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;

  // stage 1
  ctr_t     s1_c_q [3];
  dif_t     s1_w_q [3];
  dif_t     s1_h_q [3];
  // stage 2
  ctr_t     s2_c_q [3];
  dif_t     s2_w_q [3];
  dif_t     s2_h_q [3];
  ctr_mag_t s2_ca_q [3];
  dif_mag_t s2_wa_q [3];
  // stage 3
  prod_t    s3_cw_q [3];
  prod_t    s3_wc_q [3];
  prod_t    s3_hw_q [3];
  prod_t    s3_wh_q [3];
  logic     s3_face_q;
  // stage 4
  acc_t     s4_lhs_q [3];
  acc_t     s4_rhs_q [3];
  logic     s4_face_q;
  // output
  logic     hit_q;

  coord_t   in_min [3];
  coord_t   in_max [3];
  coord_t   in_st  [3];
  coord_t   in_en  [3];

  ctr_t     s1_c_d [3];
  dif_t     s1_w_d [3];
  dif_t     s1_h_d [3];
  ctr_mag_t s2_ca_d [3];
  dif_mag_t s2_wa_d [3];
  prod_t    s3_cw_d [3];
  prod_t    s3_wc_d [3];
  prod_t    s3_hw_d [3];
  prod_t    s3_wh_d [3];
  logic     s3_face_d;
  acc_t     s4_lhs_d [3];
  acc_t     s4_rhs_d [3];
  logic     hit_d;

  // ---------------------------------------------------------------- handshake
  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || rsp_o.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign req_i.ready = en[0];
  assign rsp_o.valid = v_q[NSTG-1];
  assign rsp_o.hit   = hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= req_i.valid;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // ------------------------------------------------------------ stage 1 math
  assign in_min = '{req_i.box_min_x, req_i.box_min_y, req_i.box_min_z};
  assign in_max = '{req_i.box_max_x, req_i.box_max_y, req_i.box_max_z};
  assign in_st  = '{req_i.seg_start_x, req_i.seg_start_y, req_i.seg_start_z};
  assign in_en  = '{req_i.seg_end_x, req_i.seg_end_y, req_i.seg_end_z};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_c_d[i] = (ctr_t'(in_st[i]) + ctr_t'(in_en[i]))
                - (ctr_t'(in_min[i]) + ctr_t'(in_max[i]));
      s1_w_d[i] = dif_t'(in_st[i]) - dif_t'(in_en[i]);
      s1_h_d[i] = dif_t'(in_max[i]) - dif_t'(in_min[i]);
    end
  end

  // ------------------------------------------------------------ stage 2 math
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_ca_d[i] = s1_c_q[i][CTR_W-1] ? ctr_mag_t'(-s1_c_q[i]) : ctr_mag_t'(s1_c_q[i]);
      s2_wa_d[i] = s1_w_q[i][DIF_W-1] ? dif_mag_t'(-s1_w_q[i]) : dif_mag_t'(s1_w_q[i]);
    end
  end

  // ------------------------------------------------------------ stage 3 math
  always_comb begin
    logic signed [CTR_W:0] face_rhs;
    logic signed [CTR_W:0] face_lhs;
    s3_face_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      face_rhs = (CTR_W+1)'(s2_h_q[i]) + $signed({2'b00, s2_wa_q[i]});
      face_lhs = $signed({1'b0, s2_ca_q[i]});
      if (face_lhs > face_rhs) s3_face_d = 1'b1;
    end
    for (int k = 0; k < 3; k++) begin
      s3_cw_d[k] = prod_t'(s2_c_q[AX_A[k]]) * prod_t'(s2_w_q[AX_B[k]]);
      s3_wc_d[k] = prod_t'(s2_c_q[AX_B[k]]) * prod_t'(s2_w_q[AX_A[k]]);
      s3_hw_d[k] = prod_t'(s2_h_q[AX_A[k]]) * prod_t'({1'b0, s2_wa_q[AX_B[k]]});
      s3_wh_d[k] = prod_t'(s2_h_q[AX_B[k]]) * prod_t'({1'b0, s2_wa_q[AX_A[k]]});
    end
  end

  // ------------------------------------------------------------ stage 4 math
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s4_lhs_d[k] = acc_t'(s3_cw_q[k]) - acc_t'(s3_wc_q[k]);
      s4_rhs_d[k] = acc_t'(s3_hw_q[k]) + acc_t'(s3_wh_q[k]);
    end
  end

  // ------------------------------------------------------------ stage 5 math
  // |lhs| > rhs  is  lhs > rhs or -lhs > rhs, one bit wider to keep -lhs exact
  always_comb begin
    logic signed [ACC_W:0] lx;
    logic signed [ACC_W:0] rx;
    hit_d = !s4_face_q;
    for (int k = 0; k < 3; k++) begin
      lx = (ACC_W+1)'(s4_lhs_q[k]);
      rx = (ACC_W+1)'(s4_rhs_q[k]);
      if ((lx > rx) || (-lx > rx)) hit_d = 1'b0;
    end
  end

  // --------------------------------------------------------- payload registers
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_c_q <= s1_c_d;
      s1_w_q <= s1_w_d;
      s1_h_q <= s1_h_d;
    end
    if (en[1]) begin
      s2_c_q  <= s1_c_q;
      s2_w_q  <= s1_w_q;
      s2_h_q  <= s1_h_q;
      s2_ca_q <= s2_ca_d;
      s2_wa_q <= s2_wa_d;
    end
    if (en[2]) begin
      s3_cw_q   <= s3_cw_d;
      s3_wc_q   <= s3_wc_d;
      s3_hw_q   <= s3_hw_d;
      s3_wh_q   <= s3_wh_d;
      s3_face_q <= s3_face_d;
    end
    if (en[3]) begin
      s4_lhs_q  <= s4_lhs_d;
      s4_rhs_q  <= s4_rhs_d;
      s4_face_q <= s3_face_q;
    end
    if (en[4]) begin
      hit_q <= hit_d;
    end
  end

  // ---------------------------------------------------------------- checks
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> v_q[0])
    else $error("accepted word did not reach stage 1");

  a_s4_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] && !en[3] |=> v_q[3] && $stable(s4_lhs_q[0]) && $stable(s4_face_q))
    else $error("stalled stage 4 word changed");

  a_s4_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] && en[3] |=> v_q[4])
    else $error("stage 4 word lost on its way to the output register");

  a_full_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&v_q) && !rsp_o.ready |-> !req_i.ready)
    else $error("input accepted while the whole pipe is stalled");

endmodule
